/* sv/fke_pkg.sv */
`timescale 1ns / 1ps
// Package for the FASTA k-mer extractor: constants, character codes and shared types.
package fke_pkg;

	localparam int MAX_K_DEF = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W = 1;
	localparam int KMER_W = 64;
	localparam int LEN_W = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 1'd1;

	localparam logic [LEN_W-1:0] KMER_LENGTH_RST = 6'd3;
	localparam logic [KMER_W-1:0] MAX_VALUE_RST = 64'd1;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_HEADER = 8'h3E;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_C_UP = 8'h43;
	localparam logic [7:0] CH_G_UP = 8'h47;
	localparam logic [7:0] CH_T_UP = 8'h54;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_C_LO = 8'h63;
	localparam logic [7:0] CH_G_LO = 8'h67;
	localparam logic [7:0] CH_T_LO = 8'h74;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	// run control handed back from the step logic
	typedef struct packed {
		logic [LEN_W-1:0] run_count;
		logic             in_header;
		logic             emit;
	} run_ctl_t;

endpackage

/* sv/fke_stream_ifs.sv */
`timescale 1ns / 1ps
// Stream interfaces: text bytes in, k-mer values out.
interface fke_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface fke_kmer_if;
	logic        valid;
	logic        ready;
	logic [63:0] kmer_value;

	modport source (output valid, output kmer_value, input ready);
	modport sink (input valid, input kmer_value, output ready);
endinterface

/* sv/fke_step.sv */
`timescale 1ns / 1ps
// Next-state logic for one text byte: classify, shift the window, compare.
module fke_step
	import fke_pkg::*;
#(
	parameter int MAX_K = MAX_K_DEF
) (
	input  logic [7:0]         text_byte,
	input  logic [2*MAX_K-1:0] window,
	input  logic [LEN_W-1:0]   run_count,
	input  logic               in_header,
	input  logic [LEN_W-1:0]   k_eff,
	input  logic [KMER_W-1:0]  max_value,
	output logic [2*MAX_K-1:0] window_nxt,
	output run_ctl_t           ctl
);

	localparam int WIN_W = 2 * MAX_K;

	logic [1:0]       code;
	logic             is_base;
	logic             full;
	logic [LEN_W-1:0] pos;
	logic [WIN_W-1:0] shifted;
	logic [WIN_W-1:0] built;
	logic [KMER_W-1:0] win_ext;

	always_comb begin
		code = BASE_A;
		is_base = 1'b1;
		unique case (text_byte)
			CH_A_UP, CH_A_LO: code = BASE_A;
			CH_C_UP, CH_C_LO: code = BASE_C;
			CH_G_UP, CH_G_LO: code = BASE_G;
			CH_T_UP, CH_T_LO: code = BASE_T;
			default: is_base = 1'b0;
		endcase
	end

	assign full = (run_count >= k_eff);
	// full window: new base goes into the top lane k-1; filling: into lane run_count
	assign pos = full ? (k_eff - LEN_W'(1)) : run_count;
	assign shifted = full ? (window >> 2) : window;

	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			if (LEN_W'(i) == pos) begin
				built[2*i +: 2] = full ? code : (shifted[2*i +: 2] | code);
			end else if (LEN_W'(i) < k_eff) begin
				built[2*i +: 2] = shifted[2*i +: 2];
			end else begin
				built[2*i +: 2] = 2'b00;
			end
		end
	end

	assign win_ext = KMER_W'(built);

	always_comb begin
		window_nxt = window;
		ctl.run_count = run_count;
		ctl.in_header = in_header;
		ctl.emit = 1'b0;
		priority if (text_byte == CH_NEWLINE) begin
			ctl.in_header = 1'b0;
		end else if (in_header) begin
			// header text is ignored
		end else if (text_byte == CH_HEADER) begin
			ctl.in_header = 1'b1;
			window_nxt = '0;
			ctl.run_count = '0;
		end else if (!is_base || k_eff == '0) begin
			window_nxt = '0;
			ctl.run_count = '0;
		end else begin
			window_nxt = built;
			ctl.run_count = full ? k_eff : (run_count + LEN_W'(1));
			ctl.emit = ((full || (run_count + LEN_W'(1)) == k_eff) && win_ext <= max_value);
		end
	end

endmodule

/* sv/fasta_kmer_extractor_core.sv */
`timescale 1ns / 1ps
// A text byte accepted at the input is held in the input register; when it advances, its
// k-mer is written into the output register, from which it can then be taken.
// Throughput: one byte per cycle unless the output stalls; the window update for a byte is
// computed from its input register and stored as the byte advances, so consecutive bytes chain
// with no gap. A byte that completes a k-mer waits in its input register while a held k-mer fills the output.
// Reset (arst_n low): kmer_length 3, max_value 1, run and header flag cleared, no result.
module fasta_kmer_extractor_core
	import fke_pkg::*;
#(
	parameter int MAX_K = MAX_K_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fke_text_if.sink              text_in,
	fke_kmer_if.source            kmer_out
);

	localparam int WIN_W = 2 * MAX_K;
	localparam logic [LEN_W-1:0] MAX_K_LEN = LEN_W'(MAX_K);

	logic [LEN_W-1:0]  kmer_length_q;
	logic [KMER_W-1:0] max_value_q;
	logic [WIN_W-1:0]  window_q;
	logic [LEN_W-1:0]  run_count_q;
	logic              in_header_q;

	logic              valid_s1;
	logic [7:0]        byte_s1;

	logic              out_valid_q;
	logic [KMER_W-1:0] kmer_q;

	logic [LEN_W-1:0]  k_eff;
	logic [WIN_W-1:0]  window_nxt;
	run_ctl_t          ctl;
	logic              adv_s1;

	assign k_eff = (kmer_length_q > MAX_K_LEN) ? MAX_K_LEN : kmer_length_q;

	fke_step #(
		.MAX_K(MAX_K)
	) u_step (
		.text_byte  (byte_s1),
		.window     (window_q),
		.run_count  (run_count_q),
		.in_header  (in_header_q),
		.k_eff      (k_eff),
		.max_value  (max_value_q),
		.window_nxt (window_nxt),
		.ctl        (ctl)
	);

	// a byte with no result never waits on the output side
	assign adv_s1 = valid_s1 && (!ctl.emit || !out_valid_q || kmer_out.ready);
	assign text_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KMER_LENGTH_RST;
			max_value_q <= MAX_VALUE_RST;
			window_q <= '0;
			run_count_q <= '0;
			in_header_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KMER_LENGTH: begin
					kmer_length_q <= cfg_data[LEN_W-1:0];
					window_q <= '0;
					run_count_q <= '0;
				end
				REG_MAX_VALUE: max_value_q <= cfg_data[KMER_W-1:0];
				default: ;
			endcase
		end else if (adv_s1) begin
			window_q <= window_nxt;
			run_count_q <= ctl.run_count;
			in_header_q <= ctl.in_header;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (kmer_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ctl.emit) begin
			kmer_q <= KMER_W'(window_nxt);
		end
	end

	assign kmer_out.valid = out_valid_q;
	assign kmer_out.kmer_value = kmer_q;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Testbench for the FASTA k-mer extractor: directed and random text against a predictor.
module tb;
	import fke_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 6;
	localparam int IDLE_PCT = 28;
	localparam int PHASE_BYTES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fke_text_if text_ch();
	fke_kmer_if kmer_ch();

	fasta_kmer_extractor_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.text_in(text_ch),
		.kmer_out(kmer_ch)
	);

	// predictor copy of registers and run state
	logic [LEN_W-1:0] len_reg;
	logic [KMER_W-1:0] max_reg;
	logic [KMER_W-1:0] window;
	int run_len;
	bit in_hdr;

	logic [KMER_W-1:0] kmer_q[$];
	int n_bytes = 0;
	int n_kmers = 0;
	int n_errors = 0;
	int cycles = 0;
	int hold_req = 0;
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;

	initial forever #5 clk = ~clk;

	initial forever begin
		@(posedge clk);
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d k-mers outstanding", cycles, kmer_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		n_errors++;
		if (n_errors <= 20)
			$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	task automatic model_reset();
		len_reg = KMER_LENGTH_RST;
		max_reg = MAX_VALUE_RST;
		window = '0;
		run_len = 0;
		in_hdr = 1'b0;
	endtask

	// returns 1 when the byte completes a k-mer at or below the max
	function automatic bit next_kmer(input logic [7:0] ch, output logic [KMER_W-1:0] kmer);
		int k;
		logic [1:0] code;
		bit is_base;
		logic [KMER_W-1:0] mask;
		kmer = '0;
		k = (len_reg > MAX_K_DEF) ? MAX_K_DEF : int'(len_reg);
		if (ch == CH_NEWLINE) begin
			in_hdr = 1'b0;
			return 1'b0;
		end
		if (in_hdr)
			return 1'b0;
		if (ch == CH_HEADER) begin
			in_hdr = 1'b1;
			window = '0;
			run_len = 0;
			return 1'b0;
		end
		is_base = 1'b1;
		case (ch)
			CH_A_UP, CH_A_LO: code = BASE_A;
			CH_C_UP, CH_C_LO: code = BASE_C;
			CH_G_UP, CH_G_LO: code = BASE_G;
			CH_T_UP, CH_T_LO: code = BASE_T;
			default: begin
				is_base = 1'b0;
				code = BASE_A;
			end
		endcase
		if (!is_base || k == 0) begin
			window = '0;
			run_len = 0;
			return 1'b0;
		end
		mask = (k >= 32) ? {KMER_W{1'b1}} : ((64'd1 << (2 * k)) - 64'd1);
		if (run_len >= k) begin
			window = ((window >> 2) | (64'(code) << (2 * (k - 1)))) & mask;
			run_len = k;
		end else begin
			window = window | (64'(code) << (2 * run_len));
			run_len++;
		end
		if (run_len == k && window <= max_reg) begin
			kmer = window;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KMER_LENGTH) begin
			len_reg = data[LEN_W-1:0];
			window = '0;
			run_len = 0;
		end else begin
			max_reg = data;
		end
	endtask

	// upper data bits are random: only the low six count
	task automatic set_len(input int k);
		logic [CFG_DATA_W-1:0] data;
		data = {$urandom, $urandom};
		data[LEN_W-1:0] = LEN_W'(k);
		write_reg(REG_KMER_LENGTH, data);
	endtask

	task automatic send_byte(input logic [7:0] ch);
		logic [KMER_W-1:0] kmer;
		while (src_idle && $urandom_range(99) < IDLE_PCT) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= ch;
		do @(posedge clk); while (!text_ch.ready);
		n_bytes++;
		if (next_kmer(ch, kmer))
			kmer_q.push_back(kmer);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// stop offering, wait for every k-mer, then let the pipe settle
	task automatic drain();
		text_ch.valid <= 1'b0;
		while (kmer_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_base();
		case ($urandom_range(7))
			0: return CH_A_UP;
			1: return CH_C_UP;
			2: return CH_G_UP;
			3: return CH_T_UP;
			4: return CH_A_LO;
			5: return CH_C_LO;
			6: return CH_G_LO;
			default: return CH_T_LO;
		endcase
	endfunction

	function automatic logic [KMER_W-1:0] pick_max(input int k);
		case ($urandom_range(3))
			0: return {KMER_W{1'b1}};
			1: return (k >= 32) ? {$urandom, $urandom} : ({$urandom, $urandom} >> (64 - 2 * k));
			2: return {$urandom, $urandom};
			default: return 64'($urandom_range(3));
		endcase
	endfunction

	task automatic send_record(input int n_bases, input int noise_pct, input bit with_hdr);
		if (with_hdr) begin
			send_byte(CH_HEADER);
			repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(32, 126)));
			send_byte(CH_NEWLINE);
		end
		for (int i = 0; i < n_bases; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_byte(8'($urandom_range(255)));
			else
				send_byte(rand_base());
			if ($urandom_range(39) == 0)
				send_byte(CH_NEWLINE);
		end
	endtask

	// result checker
	initial begin
		logic [KMER_W-1:0] want;
		forever begin
			@(posedge clk);
			if (arst_n && kmer_ch.valid === 1'b1 && kmer_ch.ready) begin
				if (kmer_ch.kmer_value === 'x || kmer_q.size() == 0) begin
					report_mismatch($sformatf("k-mer %h with none expected", kmer_ch.kmer_value));
				end else begin
					want = kmer_q.pop_front();
					n_kmers++;
					if (kmer_ch.kmer_value !== want)
						report_mismatch($sformatf("kmer_value %h, expected %h",
							kmer_ch.kmer_value, want));
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold on each request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		kmer_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				kmer_ch.ready <= 1'b0;
			end else begin
				kmer_ch.ready <= !snk_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic test_directed();
		// reset values: length 3, max 1
		send_text("AAaCA");
		drain();
		write_reg(REG_MAX_VALUE, {KMER_W{1'b1}});
		// newline inside a run, header with a base in it, carriage return, odd bytes
		send_text("ACgt\nTG>x A\nCA");
		send_byte(8'h0D);
		send_text("TT");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_text("G");
		drain();
	endtask

	task automatic test_lengths();
		int lens[8] = '{1, 2, 32, 31, 0, 63, 40, 3};
		foreach (lens[i]) begin
			set_len(lens[i]);
			write_reg(REG_MAX_VALUE, (i % 2 == 0) ? {KMER_W{1'b1}} : pick_max(lens[i]));
			send_record(30, 0, 1'b0);
			drain();
		end
		// longest window of all-T hits the top bits; max zero passes only all-A
		set_len(32);
		write_reg(REG_MAX_VALUE, {KMER_W{1'b1}});
		repeat (34) send_byte(CH_T_UP);
		drain();
		write_reg(REG_MAX_VALUE, '0);
		repeat (34) send_byte(CH_A_LO);
		send_byte(CH_C_UP);
		send_byte(CH_A_UP);
		drain();
	endtask

	task automatic test_random_fasta(input int n_phases);
		int k;
		int start;
		for (int p = 0; p < n_phases; p++) begin
			k = ($urandom_range(3) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
			set_len(k);
			write_reg(REG_MAX_VALUE, pick_max(k));
			src_idle = (p != 2);
			snk_idle = (p != 2);
			start = n_bytes;
			while (n_bytes - start < PHASE_BYTES)
				send_record($urandom_range(k, k + 40), (p % 3 == 1) ? 15 : 2,
					$urandom_range(3) == 0);
			drain();
		end
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	task automatic test_backpressure();
		set_len(1);
		write_reg(REG_MAX_VALUE, {KMER_W{1'b1}});
		src_idle = 1'b0;
		hold_req <= hold_req + 1;
		repeat (80) send_byte(rand_base());
		// sender waits for every k-mer, then resumes on the same run
		text_ch.valid <= 1'b0;
		while (kmer_q.size() != 0) @(posedge clk);
		src_idle = 1'b1;
		send_record(30, 0, 1'b0);
		drain();
	endtask

	initial begin
		text_ch.valid <= 1'b0;
		text_ch.text_byte <= '0;
		model_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_lengths();
		test_random_fasta(7);
		test_backpressure();
		drain();
		$display("Sent %0d text bytes, checked %0d k-mers, lengths 0..63, max 0 to all ones",
			n_bytes, n_kmers);
		$display("with headers, newlines, noise bytes, random stalls and a long output hold");
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
